// ----- rtl/nth_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nth_pkg
// Shared widths, codes and hash constants for the node tuple hash block.
// ----------------------------------------------------------------------------
package nth_pkg;

  localparam int SIZE_BITS_DEF   = 24;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int HASH_W          = 32;
  localparam int NODE_SIZE_W     = 24;
  localparam int MUL_K_W         = 17;

  typedef logic [HASH_W-1:0] hash_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_ELEM  = 1'b1
  } req_kind_t;

  localparam logic [MUL_K_W-1:0] K_CONN     = 17'd73453;
  localparam logic [MUL_K_W-1:0] K_SEED_SZ  = 17'd13477;
  localparam logic [MUL_K_W-1:0] K_ZSEED    = 17'd367;
  localparam logic [MUL_K_W-1:0] K_ODD_SEED = 17'd379;
  localparam logic [MUL_K_W-1:0] K_TR_EVEN  = 17'd5347;
  localparam logic [MUL_K_W-1:0] K_ACC_EVEN = 17'd5659;
  localparam logic [MUL_K_W-1:0] K_CUR_EVEN = 17'd373;
  localparam logic [MUL_K_W-1:0] K_TR_ODD   = 17'd5667;
  localparam logic [MUL_K_W-1:0] K_ACC_ODD  = 17'd5651;
  localparam logic [MUL_K_W-1:0] K_CUR_ODD  = 17'd277;
  localparam logic [MUL_K_W-1:0] K_IX_EVEN  = 17'd11;
  localparam logic [MUL_K_W-1:0] K_IX_ODD   = 17'd13;
  localparam logic [MUL_K_W-1:0] K_FIN_EVEN = 17'd11;
  localparam logic [MUL_K_W-1:0] K_FIN_ODD  = 17'd5;

  localparam hash_t MASK_ZSEED   = 32'h000f_ffff;
  localparam hash_t MASK_FIN     = 32'h00ff_ffff;
  localparam hash_t ADD_SEED     = 32'd9;
  localparam hash_t ADD_ZSEED    = 32'd140;
  localparam hash_t ADD_ODD_SEED = 32'd101;
  localparam hash_t ADD_TR_EVEN  = 32'd10;
  localparam hash_t ADD_TR_ODD   = 32'd13;
  localparam hash_t ADD_FIN      = 32'd1000;

endpackage
`default_nettype wire

// ----- rtl/nth_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nth_if
// Valid/ready channels for the request and response sides of the block.
// ----------------------------------------------------------------------------
interface nth_req_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [nth_pkg::HASH_W-1:0]     conn_hash;
  logic [nth_pkg::NODE_SIZE_W-1:0] node_size;
  logic [nth_pkg::HASH_W-1:0]     elem_hash;
  logic                           elem_transient;

  modport source (
    output valid, req_type, conn_hash, node_size, elem_hash, elem_transient,
    input  ready
  );
  modport sink (
    input  valid, req_type, conn_hash, node_size, elem_hash, elem_transient,
    output ready
  );
endinterface

interface nth_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [nth_pkg::HASH_W-1:0] node_hash;

  modport source (output valid, node_hash, input ready);
  modport sink (input valid, node_hash, output ready);
endinterface
`default_nettype wire

// ----- rtl/nth_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nth_front
// Accepts request transactions, tracks the open node and element position,
// drops elements that arrive with no node open and queues the rest.
// ----------------------------------------------------------------------------
module nth_front #(
  parameter int SIZE_BITS = nth_pkg::SIZE_BITS_DEF,
  parameter int ENTRY_W   = 3 + nth_pkg::HASH_W + SIZE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  nth_req_if.sink            req,
  output logic               push,
  output logic [ENTRY_W-1:0] entry,
  input  logic               full
);
  import nth_pkg::*;

  typedef struct packed {
    req_kind_t             kind;
    logic                  last;
    logic                  transient;
    hash_t                 word;
    logic [SIZE_BITS-1:0]  cnt;
  } entry_t;

  logic                 open;
  logic [SIZE_BITS-1:0] pos;
  logic [SIZE_BITS-1:0] expected;

  logic                 accept;
  logic                 is_start;
  logic [SIZE_BITS-1:0] size_in;
  logic [SIZE_BITS-1:0] pos_inc;
  entry_t               ent;

  assign req.ready = !full;
  assign accept    = req.valid && req.ready;
  assign is_start  = req_kind_t'(req.req_type) == REQ_START;
  assign size_in   = SIZE_BITS'(req.node_size);
  assign pos_inc   = pos + SIZE_BITS'(1);
  assign push      = accept && (is_start || open);
  assign entry     = ent;

  always_comb begin
    if (is_start) begin
      ent.kind      = REQ_START;
      ent.last      = size_in == '0;
      ent.transient = 1'b0;
      ent.word      = req.conn_hash;
      ent.cnt       = size_in;
    end else begin
      ent.kind      = REQ_ELEM;
      ent.last      = pos_inc == expected;
      ent.transient = req.elem_transient;
      ent.word      = req.elem_hash;
      ent.cnt       = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open     <= 1'b0;
      pos      <= '0;
      expected <= '0;
    end else if (accept) begin
      if (is_start) begin
        expected <= size_in;
        pos      <= '0;
        open     <= size_in != '0;
      end else if (open) begin
        pos  <= pos_inc;
        open <= pos_inc != expected;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/nth_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nth_queue
// Small first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module nth_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = nth_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/nth_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nth_back
// Sequencer that seeds and folds the accumulators through one shared
// constant multiplier and presents the final node hash in an output register.
// ----------------------------------------------------------------------------
module nth_back #(
  parameter int SIZE_BITS = nth_pkg::SIZE_BITS_DEF,
  parameter int ENTRY_W   = 3 + nth_pkg::HASH_W + SIZE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [ENTRY_W-1:0] q_data,
  input  logic               q_empty,
  output logic               q_pop,
  nth_rsp_if.source          rsp
);
  import nth_pkg::*;

  typedef struct packed {
    req_kind_t             kind;
    logic                  last;
    logic                  transient;
    hash_t                 word;
    logic [SIZE_BITS-1:0]  cnt;
  } entry_t;

  typedef enum logic [3:0] {
    IDLE, ST_A, ST_B, ST_C, ST_D,
    EL_A, EL_B, EL_C, EL_D, EL_E, EL_F,
    FIN_A, FIN_B, FIN_C, EMIT
  } state_t;

  state_t state;
  entry_t cur;
  hash_t  acc_even;
  hash_t  acc_odd;
  hash_t  t0;
  hash_t  t1;
  hash_t  t2;
  hash_t  res;
  hash_t  out_data;
  logic   out_valid;

  entry_t                     q_ent;
  logic                       odd;
  hash_t                      ix;
  hash_t                      mul_a;
  logic [MUL_K_W-1:0]         mul_k;
  logic [HASH_W+MUL_K_W-1:0]  prod_full;
  hash_t                      prod;
  hash_t                      seed_mix;
  hash_t                      seed;
  hash_t                      fin_mix;
  hash_t                      fin;
  hash_t                      bump;

  assign q_ent         = q_data;
  assign q_pop         = (state == IDLE) && !q_empty;
  assign odd           = cur.cnt[0];
  assign ix            = HASH_W'(cur.cnt);
  assign prod_full     = mul_a * mul_k;
  assign prod          = prod_full[HASH_W-1:0];
  assign seed_mix      = t0 ^ (t1 + ADD_SEED);
  assign seed          = (seed_mix == '0) ? (t2 & MASK_ZSEED) + ADD_ZSEED : seed_mix;
  assign fin_mix       = acc_even ^ acc_odd;
  assign fin           = (fin_mix == '0) ? t0 + t1 + ADD_FIN : fin_mix;
  assign bump          = cur.transient ? t0 + (odd ? ADD_TR_ODD : ADD_TR_EVEN) : '0;
  assign rsp.valid     = out_valid;
  assign rsp.node_hash = out_data;

  always_comb begin
    case (state)
      ST_A: begin
        mul_a = cur.word;
        mul_k = K_CONN;
      end
      ST_B: begin
        mul_a = ix;
        mul_k = K_SEED_SZ;
      end
      ST_C: begin
        mul_a = ix;
        mul_k = K_ZSEED;
      end
      ST_D: begin
        mul_a = ix;
        mul_k = K_ODD_SEED;
      end
      EL_A: begin
        mul_a = ix;
        mul_k = odd ? K_TR_ODD : K_TR_EVEN;
      end
      EL_C: begin
        mul_a = t1;
        mul_k = odd ? K_CUR_ODD : K_CUR_EVEN;
      end
      EL_D: begin
        mul_a = odd ? acc_odd : acc_even;
        mul_k = odd ? K_ACC_ODD : K_ACC_EVEN;
      end
      EL_E: begin
        mul_a = ix;
        mul_k = odd ? K_IX_ODD : K_IX_EVEN;
      end
      FIN_A: begin
        mul_a = acc_even & MASK_FIN;
        mul_k = K_FIN_EVEN;
      end
      FIN_B: begin
        mul_a = acc_odd & MASK_FIN;
        mul_k = K_FIN_ODD;
      end
      default: begin
        mul_a = '0;
        mul_k = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      acc_even  <= '0;
      acc_odd   <= '0;
    end else begin
      if (out_valid && rsp.ready && state != EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (!q_empty) begin
            cur   <= q_ent;
            state <= (q_ent.kind == REQ_START) ? ST_A : EL_A;
          end
        end
        ST_A: begin
          t0    <= prod;
          state <= ST_B;
        end
        ST_B: begin
          t1    <= prod;
          state <= ST_C;
        end
        ST_C: begin
          t2    <= prod;
          state <= ST_D;
        end
        ST_D: begin
          acc_odd  <= prod + ADD_ODD_SEED;
          acc_even <= seed;
          res      <= seed;
          state    <= cur.last ? EMIT : IDLE;
        end
        EL_A: begin
          t0    <= prod;
          state <= EL_B;
        end
        EL_B: begin
          t1    <= cur.word + bump;
          state <= EL_C;
        end
        EL_C: begin
          t1    <= prod;
          state <= EL_D;
        end
        EL_D: begin
          t0    <= prod;
          state <= EL_E;
        end
        EL_E: begin
          t2    <= prod;
          state <= EL_F;
        end
        EL_F: begin
          if (odd) begin
            acc_odd <= t0 ^ (t1 + t2);
          end else begin
            acc_even <= (t0 + t2) ^ t1;
          end
          state <= cur.last ? FIN_A : IDLE;
        end
        FIN_A: begin
          t0    <= prod;
          state <= FIN_B;
        end
        FIN_B: begin
          t1    <= prod;
          state <= FIN_C;
        end
        FIN_C: begin
          res   <= fin;
          state <= EMIT;
        end
        EMIT: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_hash_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.node_hash != '0)
    else $error("node hash presented as zero");

  a_pop_starts_work: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != IDLE)
    else $error("queue entry popped but sequencer stayed idle");

  a_even_only_on_update: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_D || state == EL_F) |=> $stable(acc_even))
    else $error("even accumulator changed outside a seed or fold step");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == EMIT)
    else $error("result register loaded outside the emit step");

endmodule
`default_nettype wire

// ----- rtl/node_tuple_hash.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// node_tuple_hash
// Tuple hash over a connective hash and a stream of element hashes.
// ----------------------------------------------------------------------------
// A queued transaction occupies the back sequencer for steps ST_A to ST_D
// (start that opens a node), ST_A to ST_D and EMIT (start of an empty node,
// including the result), EL_A to EL_F (element) or EL_A to EL_F, FIN_A to
// FIN_C and EMIT (last element, including the result). The steps take their
// products in turn from the shared 32x17 constant multiplier, one product per
// cycle. EMIT loads the result into the output register once it is free or
// being read. Synchronous reset clears the node state, queue and output valid.
// ----------------------------------------------------------------------------
module node_tuple_hash #(
  parameter int SIZE_BITS   = nth_pkg::SIZE_BITS_DEF,
  parameter int QUEUE_DEPTH = nth_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  nth_req_if.sink   req,
  nth_rsp_if.source rsp
);
  import nth_pkg::*;

  localparam int ENTRY_W = 3 + HASH_W + SIZE_BITS;

  logic               push;
  logic [ENTRY_W-1:0] wr_entry;
  logic               full;
  logic               pop;
  logic [ENTRY_W-1:0] rd_entry;
  logic               empty;

  nth_front #(
    .SIZE_BITS (SIZE_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .push  (push),
    .entry (wr_entry),
    .full  (full)
  );

  nth_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_entry),
    .full    (full),
    .pop     (pop),
    .rd_data (rd_entry),
    .empty   (empty)
  );

  nth_back #(
    .SIZE_BITS (SIZE_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (rd_entry),
    .q_empty (empty),
    .q_pop   (pop),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for node_tuple_hash. Start and element transactions go
// through directed and random phases with idling on either side. Each accepted
// request updates a bit-accurate predictor, and the node hashes that come out
// are checked in order against it.
// ----------------------------------------------------------------------------
module tb;
  import nth_pkg::*;

  localparam int          SIZE_BITS    = SIZE_BITS_DEF;
  localparam logic [31:0] SIZE_MASK    = 32'hffff_ffff >> (32 - SIZE_BITS);
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 24;
  localparam int          PHASE_ITEMS  = 257;

  typedef struct packed {
    req_kind_t              kind;
    hash_t                  conn;
    logic [NODE_SIZE_W-1:0] node_len;
    hash_t                  elem;
    logic                   transient;
  } req_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nth_req_if req_ch ();
  nth_rsp_if rsp_ch ();

  node_tuple_hash dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hash_t       even_acc;
  hash_t       odd_acc;
  logic [31:0] elem_ix;
  logic [31:0] node_elems;
  logic        node_active;
  hash_t       pending_hashes[$];
  hash_t       want_hash;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          src_idle_pct = 0;
  int          rcv_stall_pct = 0;
  bit          node_in_flight = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic predict_node_hash(input req_item_t it);
    logic [31:0] sz;
    logic [31:0] ix;
    hash_t       seed;
    hash_t       cur;
    hash_t       fold;
    if (it.kind == REQ_START) begin
      sz = 32'(it.node_len) & SIZE_MASK;
      seed = (32'd73453 * it.conn) ^ (32'd13477 * sz + 32'd9);
      if (seed == '0) begin
        seed = ((32'd367 * sz) & 32'h000f_ffff) + 32'd140;
      end
      even_acc = seed;
      odd_acc = 32'd379 * sz + 32'd101;
      elem_ix = '0;
      node_elems = sz;
      node_active = (sz != 0);
      if (sz == 0) begin
        pending_hashes.push_back(seed);
      end
    end else if (node_active) begin
      ix = elem_ix;
      cur = it.elem;
      if (!ix[0]) begin
        if (it.transient) begin
          cur = cur + 32'd5347 * ix + 32'd10;
        end
        even_acc = (32'd5659 * even_acc + 32'd11 * ix) ^ (32'd373 * cur);
      end else begin
        if (it.transient) begin
          cur = cur + 32'd5667 * ix + 32'd13;
        end
        odd_acc = (32'd5651 * odd_acc) ^ (32'd277 * cur + 32'd13 * ix);
      end
      elem_ix = (ix + 32'd1) & SIZE_MASK;
      if (elem_ix == node_elems) begin
        node_active = 1'b0;
        fold = even_acc ^ odd_acc;
        if (fold == '0) begin
          fold = 32'd11 * (even_acc & 32'h00ff_ffff) + 32'd5 * (odd_acc & 32'h00ff_ffff)
                 + 32'd1000;
        end
        pending_hashes.push_back(fold);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
      even_acc = '0;
      odd_acc = '0;
      elem_ix = '0;
      node_elems = '0;
      node_active = 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_node_hash(req_item_t'{req_kind_t'(req_ch.req_type), req_ch.conn_hash,
                                      req_ch.node_size, req_ch.elem_hash,
                                      req_ch.elem_transient});
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_hashes.size() == 0) begin
          report_mismatch($sformatf("unexpected node_hash %08h", rsp_ch.node_hash));
        end else begin
          want_hash = pending_hashes.pop_front();
          if (rsp_ch.node_hash !== want_hash) begin
            report_mismatch($sformatf("node_hash %08h, expected %08h",
                                      rsp_ch.node_hash, want_hash));
          end
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(negedge clk);
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic hash_t mod_inv(input hash_t a);
    hash_t x;
    x = a;
    repeat (5) x = x * (32'd2 - a * x);
    return x;
  endfunction

  function automatic hash_t zero_seed_conn(input logic [NODE_SIZE_W-1:0] len);
    logic [31:0] sz;
    sz = 32'(len) & SIZE_MASK;
    return mod_inv(32'd73453) * (32'd13477 * sz + 32'd9);
  endfunction

  function automatic hash_t rand_hash();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 16) return '1;
    return $urandom;
  endfunction

  function automatic req_item_t start_item(input hash_t conn,
                                           input logic [NODE_SIZE_W-1:0] len);
    return req_item_t'{REQ_START, conn, len, hash_t'($urandom), 1'($urandom_range(1))};
  endfunction

  function automatic req_item_t elem_item(input hash_t elem, input logic transient);
    return req_item_t'{REQ_ELEM, hash_t'($urandom),
                       NODE_SIZE_W'($urandom_range(24'hff_ffff)), elem, transient};
  endfunction

  task automatic send_item(input req_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= it.kind;
    req_ch.conn_hash      <= it.conn;
    req_ch.node_size      <= it.node_len;
    req_ch.elem_hash      <= it.elem;
    req_ch.elem_transient <= it.transient;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
  endtask

  task automatic send_node(input hash_t conn, input logic [NODE_SIZE_W-1:0] len,
                           input int n_elems);
    send_item(start_item(conn, len));
    repeat (n_elems) send_item(elem_item(rand_hash(), 1'($urandom_range(1))));
  endtask

  task automatic test_stray_elements;
    send_item(elem_item('1, 1'b1));
    send_item(elem_item('0, 1'b0));
  endtask

  task automatic test_empty_and_extremes;
    send_item(start_item('0, '0));
    send_item(start_item('1, '0));
    send_item(start_item('1, 24'd1));
    send_item(elem_item('1, 1'b0));
  endtask

  task automatic test_transient_positions;
    send_item(start_item($urandom, 24'd4));
    send_item(elem_item('0, 1'b1));
    send_item(elem_item('1, 1'b1));
    send_item(elem_item(32'h1234_5678, 1'b0));
    send_item(elem_item(32'ha5a5_a5a5, 1'b1));
  endtask

  task automatic test_restart_open_node;
    send_item(start_item($urandom, 24'hff_ffff));
    send_item(elem_item($urandom, 1'b1));
    send_item(elem_item($urandom, 1'b1));
    send_item(start_item($urandom, 24'd2));
    send_item(elem_item($urandom, 1'b0));
    send_item(elem_item($urandom, 1'b1));
  endtask

  task automatic test_zero_seed;
    send_item(start_item(zero_seed_conn('0), '0));
    send_item(start_item(zero_seed_conn(24'd1), 24'd1));
    send_item(elem_item($urandom, 1'b0));
  endtask

  // A one-element node whose even fold lands exactly on the odd seed, so the
  // two accumulators cancel and the final hash has to be replaced.
  task automatic test_zero_fold;
    hash_t conn;
    hash_t seed;
    hash_t bumped;
    conn = $urandom;
    seed = (32'd73453 * conn) ^ (32'd13477 + 32'd9);
    if (seed == '0) begin
      seed = 32'd367 + 32'd140;
    end
    bumped = mod_inv(32'd373) * ((32'd5659 * seed) ^ (32'd379 + 32'd101));
    send_item(start_item(conn, 24'd1));
    send_item(elem_item(bumped - 32'd10, 1'b1));
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    int                     sent;
    int                     pick;
    int                     n_elems;
    logic [NODE_SIZE_W-1:0] len;
    hash_t                  conn;
    src_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        if (!node_in_flight) begin
          repeat ($urandom_range(1, 3)) send_item(elem_item($urandom, 1'($urandom_range(1))));
        end
      end else begin
        if (pick < 88) begin
          pick = $urandom_range(99);
          len = (pick < 70) ? NODE_SIZE_W'($urandom_range(0, 6)) :
                (pick < 96) ? NODE_SIZE_W'($urandom_range(7, 40)) :
                NODE_SIZE_W'($urandom_range(41, 160));
          n_elems = int'(len);
        end else begin
          len = ($urandom_range(1) != 0) ? NODE_SIZE_W'($urandom_range(24'hff_ffff)) :
                NODE_SIZE_W'($urandom_range(2, 20));
          n_elems = (len == '0) ? 0 :
                    int'($urandom_range(0, (len > 24'd7) ? 32'd6 : 32'(len) - 32'd1));
        end
        conn = ($urandom_range(99) < 4) ? zero_seed_conn(len) : rand_hash();
        send_node(conn, len, n_elems);
        node_in_flight = (n_elems < int'(len));
        sent = sent + 1 + n_elems;
      end
    end
  endtask

  initial begin
    req_ch.valid          = 1'b0;
    req_ch.req_type       = REQ_START;
    req_ch.conn_hash      = '0;
    req_ch.node_size      = '0;
    req_ch.elem_hash      = '0;
    req_ch.elem_transient = 1'b0;
    rsp_ch.ready          = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_stray_elements();
    test_empty_and_extremes();
    test_transient_positions();
    test_restart_open_node();
    test_zero_seed();
    test_zero_fold();
    test_random_traffic(PHASE_ITEMS, 0, 0);
    test_random_traffic(PHASE_ITEMS, 68, 0);
    test_random_traffic(PHASE_ITEMS, 0, 68);
    test_random_traffic(PHASE_ITEMS, 20, 20);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    rcv_stall_pct = 0;
    while (pending_hashes.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
